/* rtl/uwg_pkg.sv */
// shared types, constants and the cordic angle table for the waypoint generator
// no dependencies
`timescale 1ns / 1ps
package uwg_pkg;

	localparam int MAX_STEPS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CQ            = 29;
	localparam int CORDIC_ITERS  = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int IDX_W         = 7;

	localparam longint CORDIC_GAIN = 64'sd326016436;
	localparam longint PI_Q        = 64'sd1686629713;
	localparam longint TWO_PI_Q    = 64'sd3373259426;
	localparam longint HALF_PI_Q   = 64'sd843314856;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TSTEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// per-waypoint data riding along the cell chain
	typedef struct packed {
		logic              flip;
		logic [31:0]       heading;
		logic [IDX_W-1:0]  index;
		logic              last;
	} side_t;

	function automatic logic signed [31:0] atan_at(input int i);
		logic signed [31:0] v;
		case (i)
			0:  v = 32'sd421657428;
			1:  v = 32'sd248918915;
			2:  v = 32'sd131521918;
			3:  v = 32'sd66762579;
			4:  v = 32'sd33510843;
			5:  v = 32'sd16771758;
			6:  v = 32'sd8387925;
			7:  v = 32'sd4194219;
			8:  v = 32'sd2097141;
			9:  v = 32'sd1048575;
			10: v = 32'sd524288;
			11: v = 32'sd262144;
			12: v = 32'sd131072;
			13: v = 32'sd65536;
			14: v = 32'sd32768;
			15: v = 32'sd16384;
			16: v = 32'sd8192;
			17: v = 32'sd4096;
			18: v = 32'sd2048;
			19: v = 32'sd1024;
			20: v = 32'sd512;
			21: v = 32'sd256;
			22: v = 32'sd128;
			23: v = 32'sd64;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/uwg_red_cell.sv */
// one cell of the modulo 2*pi reduction chain: conditional subtract of 2*pi << J
// depends on uwg_pkg
`timescale 1ns / 1ps
module uwg_red_cell #(
	parameter int MW = 46,
	parameter int J  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_in,
	input  logic             neg_in,
	input  logic [MW-1:0]    mag_in,
	input  uwg_pkg::side_t   side_in,
	output logic             vld_q,
	output logic             neg_q,
	output logic [MW-1:0]    mag_q,
	output uwg_pkg::side_t   side_q
);
	import uwg_pkg::*;

	localparam logic [63:0] SUB64 = 64'(TWO_PI_Q) << J;
	localparam logic [MW-1:0] SUB = SUB64[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_q  <= neg_in;
			side_q <= side_in;
			mag_q  <= (mag_in >= SUB) ? mag_in - SUB : mag_in;
		end
	end

endmodule

/* rtl/uwg_fold.sv */
// restores the sign of the reduced angle and folds it into [-pi/2, pi/2]
// depends on uwg_pkg
`timescale 1ns / 1ps
module uwg_fold (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic               neg_in,
	input  logic [31:0]        mag_in,
	input  uwg_pkg::side_t     side_in,
	output logic               vld_q,
	output logic signed [31:0] r_q,
	output uwg_pkg::side_t     side_q
);
	import uwg_pkg::*;

	localparam logic signed [33:0] T  = 34'(TWO_PI_Q);
	localparam logic signed [33:0] P  = 34'(PI_Q);
	localparam logic signed [33:0] HP = 34'(HALF_PI_Q);

	logic signed [33:0] r0, r1, r2;
	logic flip;
	side_t side_f;

	always_comb begin
		r0 = neg_in ? -$signed({2'b00, mag_in}) : $signed({2'b00, mag_in});
		if (r0 > P) r1 = r0 - T;
		else if (r0 < -P) r1 = r0 + T;
		else r1 = r0;
		flip = 1'b0;
		if (r1 > HP) begin
			r2 = r1 - P;
			flip = 1'b1;
		end else if (r1 < -HP) begin
			r2 = r1 + P;
			flip = 1'b1;
		end else begin
			r2 = r1;
		end
		side_f      = side_in;
		side_f.flip = flip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q    <= r2[31:0];
			side_q <= side_f;
		end
	end

endmodule

/* rtl/uwg_cordic_cell.sv */
// one rotation-mode cordic iteration with floor shifts, registered
// depends on uwg_pkg
`timescale 1ns / 1ps
module uwg_cordic_cell #(
	parameter int I = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic signed [31:0] r_in,
	input  uwg_pkg::side_t     side_in,
	output logic               vld_q,
	output logic signed [31:0] x_q,
	output logic signed [31:0] y_q,
	output logic signed [31:0] r_q,
	output uwg_pkg::side_t     side_q
);
	import uwg_pkg::*;

	localparam logic signed [31:0] ATAN = atan_at(I);

	logic signed [31:0] xs, ys;

	assign xs = x_in >>> I;
	assign ys = y_in >>> I;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q <= side_in;
			if (!r_in[31]) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				r_q <= r_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				r_q <= r_in + ATAN;
			end
		end
	end

endmodule

/* rtl/uwg_post.sv */
// rounds cordic sine and cosine to the pose format and scales them by v*dt
// depends on uwg_pkg
`timescale 1ns / 1ps
module uwg_post #(
	parameter int FRAC_BITS = 16,
	parameter int VW        = 23,
	parameter int SW        = 19,
	parameter int PW        = 43
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 vld_in,
	input  logic signed [31:0]   x_in,
	input  logic signed [31:0]   y_in,
	input  uwg_pkg::side_t       side_in,
	input  logic [VW-1:0]        vdt,
	output logic                 vld_s2,
	output logic signed [PW-1:0] psin_s2,
	output logic signed [PW-1:0] pcos_s2,
	output uwg_pkg::side_t       side_s2
);
	import uwg_pkg::*;

	localparam int SH = CQ - FRAC_BITS;
	localparam logic signed [31:0] RND = 32'sd1 <<< (SH - 1);

	logic signed [31:0] fx, fy, cx, cy;
	logic signed [SW-1:0] s_s1, c_s1;
	logic vld_s1;
	side_t side_s1;
	logic signed [VW:0] vdt_s;

	always_comb begin
		fx = side_in.flip ? -x_in : x_in;
		fy = side_in.flip ? -y_in : y_in;
		cx = (fx + RND) >>> SH;
		cy = (fy + RND) >>> SH;
	end

	assign vdt_s = $signed({1'b0, vdt});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= cx[SW-1:0];
			s_s1    <= cy[SW-1:0];
			side_s1 <= side_in;
			psin_s2 <= PW'(vdt_s * s_s1);
			pcos_s2 <= PW'(vdt_s * c_s1);
			side_s2 <= side_s1;
		end
	end

endmodule

/* rtl/unicycle_waypoint_generator.sv */
// top level of the unicycle waypoint generator: control, heading issue, pose accumulators
// depends on uwg_pkg, uwg_red_cell, uwg_fold, uwg_cordic_cell, uwg_post
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | in
//  request | in_valid in_ready turn_rate                     | in
//  pose    | out_valid out_ready pos_x pos_y heading         | out
//          | step_index last                                 |
//
// a request passes a setup state after its beat, then issues one mid-step heading per
// cycle, while the row advances, into the cell row (15 reduction cells, fold, 24 cordic
// cells, two post stages, output register); poses leave one per cycle unless the output
// stalls. the next request is taken once the last beat has left. a stalled pose beat
// freezes the whole row. cfg writes are always ready.
`timescale 1ns / 1ps
module unicycle_waypoint_generator #(
	parameter int MAX_STEPS = uwg_pkg::MAX_STEPS_DEF,
	parameter int FRAC_BITS = uwg_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [uwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [19:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [19:0]            turn_rate,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            pos_x,
	output logic signed [31:0]            pos_y,
	output logic signed [31:0]            heading,
	output logic [uwg_pkg::IDX_W-1:0]     step_index,
	output logic                          last
);
	import uwg_pkg::*;

	localparam int SHQ  = CQ - FRAC_BITS;
	localparam int MW   = 33 + SHQ;
	localparam int NRED = MW - 31;
	localparam int VW   = 39 - FRAC_BITS;
	localparam int SW   = FRAC_BITS + 3;
	localparam int PW   = VW + 1 + SW;
	localparam int EW   = PW + 1;
	localparam logic [IDX_W-1:0] MAXC = IDX_W'(MAX_STEPS);

	state_t state_q, state_d;

	logic [18:0] speed_q;
	logic [19:0] tstep_q;
	logic [6:0]  count_q;
	logic signed [19:0] omega_q;
	logic [IDX_W-1:0] lim_q, cnt_q;
	logic [VW-1:0] vdt_q;
	logic signed [40:0] rot_q;
	logic signed [31:0] hiss_q, delta, half, hnext;
	logic signed [32:0] mid, hsum;
	logic signed [MW:0] ang;
	logic [MW-1:0] mag0;
	logic adv, issue, in_beat, out_beat;
	side_t side0;
	logic signed [31:0] acc_x_q, acc_y_q, head_q;
	logic [IDX_W-1:0] idx_q;
	logic last_q, ovld_q;

	assign cfg_ready = 1'b1;
	assign adv      = !ovld_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign out_beat = ovld_q && out_ready;
	assign issue    = (state_q == ST_ISSUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 19'd13107;
			tstep_q <= 20'd131072;
			count_q <= 7'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED: speed_q <= cfg_data[18:0];
				REG_TSTEP: tstep_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// heading issue side
	always_comb begin
		delta = 32'(rot_q >>> FRAC_BITS);
		half  = 32'(rot_q >>> (FRAC_BITS + 1));
		mid   = {hiss_q[31], hiss_q} + {half[31], half};
		hsum  = {hiss_q[31], hiss_q} + {delta[31], delta};
		if (hsum[32] != hsum[31]) hnext = hsum[32] ? 32'sh80000000 : 32'sh7fffffff;
		else hnext = hsum[31:0];
		ang  = $signed({{(MW-32){mid[32]}}, mid}) <<< SHQ;
		mag0 = ang[MW] ? MW'(-ang) : ang[MW-1:0];
		side0.flip    = 1'b0;
		side0.heading = hnext;
		side0.index   = cnt_q + 1'b1;
		side0.last    = (cnt_q + 1'b1) == lim_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_beat) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_ISSUE;
			ST_ISSUE: if (adv && side0.last) state_d = ST_DRAIN;
			ST_DRAIN: if (out_beat && last_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			hiss_q  <= '0;
			lim_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				if (count_q == 7'd0) lim_q <= IDX_W'(1);
				else if (count_q > MAXC) lim_q <= MAXC;
				else lim_q <= count_q;
			end
			if (state_q == ST_SETUP) begin
				cnt_q  <= '0;
				hiss_q <= '0;
			end else if (issue && adv) begin
				cnt_q  <= cnt_q + 1'b1;
				hiss_q <= hnext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) omega_q <= turn_rate;
		if (state_q == ST_SETUP) begin
			vdt_q <= VW'(({20'd0, speed_q} * {19'd0, tstep_q}) >> FRAC_BITS);
			rot_q <= $signed({1'b0, tstep_q}) * omega_q;
		end
	end

	// reduction cells
	logic           rv [NRED+1];
	logic           rn [NRED+1];
	logic [MW-1:0]  rm [NRED+1];
	side_t          rs [NRED+1];

	assign rv[0] = issue;
	assign rn[0] = ang[MW];
	assign rm[0] = mag0;
	assign rs[0] = side0;

	for (genvar k = 0; k < NRED; k++) begin : g_red
		uwg_red_cell #(.MW(MW), .J(NRED-1-k)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(rv[k]), .neg_in(rn[k]), .mag_in(rm[k]), .side_in(rs[k]),
			.vld_q(rv[k+1]), .neg_q(rn[k+1]), .mag_q(rm[k+1]), .side_q(rs[k+1])
		);
	end

	logic               cv [CORDIC_ITERS+1];
	logic signed [31:0] cx [CORDIC_ITERS+1];
	logic signed [31:0] cy [CORDIC_ITERS+1];
	logic signed [31:0] cr [CORDIC_ITERS+1];
	side_t              cs [CORDIC_ITERS+1];

	uwg_fold u_fold (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_in(rv[NRED]), .neg_in(rn[NRED]), .mag_in(rm[NRED][31:0]), .side_in(rs[NRED]),
		.vld_q(cv[0]), .r_q(cr[0]), .side_q(cs[0])
	);

	assign cx[0] = 32'(CORDIC_GAIN);
	assign cy[0] = '0;

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
		uwg_cordic_cell #(.I(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(cv[i]), .x_in(cx[i]), .y_in(cy[i]), .r_in(cr[i]), .side_in(cs[i]),
			.vld_q(cv[i+1]), .x_q(cx[i+1]), .y_q(cy[i+1]), .r_q(cr[i+1]), .side_q(cs[i+1])
		);
	end

	logic pvld;
	logic signed [PW-1:0] psin, pcos;
	side_t pside;

	uwg_post #(.FRAC_BITS(FRAC_BITS), .VW(VW), .SW(SW), .PW(PW)) u_post (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_in(cv[CORDIC_ITERS]), .x_in(cx[CORDIC_ITERS]), .y_in(cy[CORDIC_ITERS]),
		.side_in(cs[CORDIC_ITERS]), .vdt(vdt_q),
		.vld_s2(pvld), .psin_s2(psin), .pcos_s2(pcos), .side_s2(pside)
	);

	// pose accumulators double as the output register
	localparam logic signed [PW-1:0] RNDP = PW'(1) <<< (FRAC_BITS - 1);
	logic signed [PW-1:0] dx, dy;
	logic signed [EW-1:0] sx, sy;
	logic signed [31:0] nx, ny;

	always_comb begin
		dx = (psin + RNDP) >>> FRAC_BITS;
		dy = (pcos + RNDP) >>> FRAC_BITS;
		sx = EW'(acc_x_q) - EW'(dx);
		sy = EW'(acc_y_q) + EW'(dy);
		if (sx > EW'(32'sh7fffffff)) nx = 32'sh7fffffff;
		else if (sx < -EW'(33'sh080000000)) nx = 32'sh80000000;
		else nx = sx[31:0];
		if (sy > EW'(32'sh7fffffff)) ny = 32'sh7fffffff;
		else if (sy < -EW'(33'sh080000000)) ny = 32'sh80000000;
		else ny = sy[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q  <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			last_q  <= 1'b0;
		end else begin
			if (in_beat) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
			end else if (adv && pvld) begin
				acc_x_q <= nx;
				acc_y_q <= ny;
				last_q  <= pside.last;
			end
			if (adv) ovld_q <= pvld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pvld) begin
			head_q <= pside.heading;
			idx_q  <= pside.index;
		end
	end

	assign out_valid  = ovld_q;
	assign pos_x      = acc_x_q;
	assign pos_y      = acc_y_q;
	assign heading    = head_q;
	assign step_index = idx_q;
	assign last       = last_q;

	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> !ovld_q) else $error("request taken while a pose is pending");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && last_q) |-> (idx_q == lim_q)) else $error("last beat at wrong index");
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && last_q) |=> in_ready) else $error("not idle after last beat");
	a_no_issue_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DRAIN || state_q == ST_IDLE))
		else $error("drain left to a busy state");

endmodule

/* test/uwg_checker.sv */
// pose checker for the unicycle waypoint generator: tracks cfg beats, predicts poses per request
// and compares each pose beat against the oldest prediction; depends on uwg_pkg
`timescale 1ns / 1ps
module uwg_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [uwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [19:0]                   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic signed [19:0]            turn_rate,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            heading,
	input  logic [uwg_pkg::IDX_W-1:0]     step_index,
	input  logic                          last,
	output int                            errors,
	output int                            pending
);
	import uwg_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int NSTEP = MAX_STEPS_DEF;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] hdg;
		logic [IDX_W-1:0]   idx;
		logic               fin;
	} pose_t;

	localparam longint ATAN_TAB [CORDIC_ITERS] = '{
		421657428, 248918915, 131521918, 66762579, 33510843,
		16771758, 8387925, 4194219, 2097141, 1048575,
		524288, 262144, 131072, 65536, 32768, 16384,
		8192, 4096, 2048, 1024, 512, 256, 128, 64
	};

	logic [18:0] speed;
	logic [19:0] tstep;
	logic [6:0]  count_reg;
	pose_t       pose_q[$];

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic mid_sin_cos(input longint angle, output longint s, output longint c);
		longint r, x, y, nx;
		bit flip;
		r = (angle * (64'sd1 <<< (CQ - FB))) % TWO_PI_Q;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (r > PI_Q) r -= TWO_PI_Q;
		else if (r < -PI_Q) r += TWO_PI_Q;
		if (r > HALF_PI_Q) begin
			r -= PI_Q;
			flip = 1;
		end else if (r < -HALF_PI_Q) begin
			r += PI_Q;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r -= ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r += ATAN_TAB[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + (64'sd1 <<< (CQ - FB - 1))) >>> (CQ - FB);
		s = (y + (64'sd1 <<< (CQ - FB - 1))) >>> (CQ - FB);
	endtask

	task automatic predict_poses(input logic signed [19:0] omega);
		longint vdt, rot, delta, half, ax, ay, ah, s, c, rnd;
		int n;
		pose_t p;
		n = count_reg;
		if (n == 0) n = 1;
		if (n > NSTEP) n = NSTEP;
		rnd = 64'sd1 <<< (FB - 1);
		vdt = longint'((64'(speed) * 64'(tstep)) >> FB);
		rot = longint'(tstep) * longint'(omega);
		delta = sat32(rot >>> FB);
		half = rot >>> (FB + 1);
		ax = 0;
		ay = 0;
		ah = 0;
		for (int k = 1; k <= n; k++) begin
			mid_sin_cos(ah + half, s, c);
			ax = sat32(ax - ((vdt * s + rnd) >>> FB));
			ay = sat32(ay + ((vdt * c + rnd) >>> FB));
			ah = sat32(ah + delta);
			p.x = ax[31:0];
			p.y = ay[31:0];
			p.hdg = ah[31:0];
			p.idx = k[IDX_W-1:0];
			p.fin = (k == n);
			pose_q.push_back(p);
		end
	endtask

	assign pending = pose_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed <= 19'd13107;
			tstep <= 20'd131072;
			count_reg <= 7'd3;
			errors <= 0;
			pose_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPEED: speed <= cfg_data[18:0];
					REG_TSTEP: tstep <= cfg_data;
					REG_COUNT: count_reg <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_poses(turn_rate);
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					$display("%0t: unexpected pose beat x=%0d y=%0d", $time, pos_x, pos_y);
					errors <= errors + 1;
				end else begin
					pose_t e;
					e = pose_q.pop_front();
					if (e.x !== pos_x || e.y !== pos_y || e.hdg !== heading
							|| e.idx !== step_index || e.fin !== last) begin
						$display("%0t: pose mismatch expected x=%0d y=%0d h=%0d i=%0d l=%0b",
							$time, e.x, e.y, e.hdg, e.idx, e.fin);
						$display("%0t:               actual   x=%0d y=%0d h=%0d i=%0d l=%0b",
							$time, pos_x, pos_y, heading, step_index, last);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

/* test/unicycle_waypoint_generator_tb.sv */
// testbench top for the unicycle waypoint generator: clock, reset, request and cfg stimulus,
// random pose back-pressure and the verdict; depends on uwg_pkg, uwg_checker and the block
`timescale 1ns / 1ps
module unicycle_waypoint_generator_tb;
	import uwg_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [19:0]          cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic signed [19:0]   turn_rate = '0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic signed [31:0]   pos_x, pos_y, heading;
	logic [IDX_W-1:0]     step_index;
	logic                 last;
	int                   errors, pending;
	int                   quiet_cycles;
	bit                   calm;

	localparam int WATCHDOG = 3000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	unicycle_waypoint_generator dut (.*);
	uwg_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// pose sink: random stall per beat, calm phases stall never
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("FAIL unicycle_waypoint_generator");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_turn(input logic signed [19:0] tr);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		turn_rate <= tr;
		do @(posedge clk); while (!in_ready);
	endtask

	// end of a phase: stop the request beat, let all poses drain and the row settle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || !in_ready) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic setup(input logic [19:0] v, input logic [19:0] dt, input logic [19:0] n);
		write_reg(REG_SPEED, v);
		write_reg(REG_TSTEP, dt);
		write_reg(REG_COUNT, n);
	endtask

	function automatic logic signed [19:0] rand_turn();
		if ($urandom_range(0, 4) == 0)
			return 20'($urandom_range(0, 20'hFFFFF));
		return 20'(int'($urandom_range(0, 524288)) - 262144);
	endfunction

	initial begin
		logic signed [19:0] dir_turns [7] = '{0, 262144, -262144, 1, -1, 524287, -524288};
		logic [19:0] v, dt, n;
		@(posedge arst_n);
		calm = 0;
		// reset settings first
		foreach (dir_turns[i]) send_turn(dir_turns[i]);
		drain();
		setup(20'd327680, 20'd655360, 20'd64);
		send_turn(20'sd262144);
		send_turn(-20'sd262144);
		drain();
		// zero count acts as one, oversize count clamps, zero time step stays at origin
		setup(20'd0, 20'd1, 20'd0);
		send_turn(20'sd100000);
		drain();
		setup(20'hFFFFF, 20'hFFFFF, 20'd127);
		send_turn(20'sd524287);
		drain();
		setup(20'd65536, 20'd0, 20'd2);
		send_turn(-20'sd77777);
		// unknown index is dropped
		drain();
		write_reg(REG_NONE, 20'd5);
		send_turn(20'sd65536);
		send_turn(20'sd3);
		drain();
		for (int ph = 0; ph < 14; ph++) begin
			calm = (ph % 4 == 3);
			v = (ph % 5 == 4) ? 20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(0, 327680));
			dt = (ph % 5 == 4) ? 20'($urandom_range(0, 20'hFFFFF)) : 20'($urandom_range(1, 655360));
			if (ph == 6)
				n = 20'd64;
			else if (ph % 5 == 4)
				n = 20'($urandom_range(0, 20'hFFFFF));
			else
				n = 20'($urandom_range(1, 6));
			setup(v, dt, n);
			for (int k = 0; k < 25; k++) send_turn(rand_turn());
			drain();
		end
		if (errors == 0)
			$display("PASS unicycle_waypoint_generator");
		else
			$display("FAIL unicycle_waypoint_generator");
		$finish;
	end

endmodule
